// ----- sv/vcm_pkg.sv -----
package vcm_pkg;

  localparam int VALUE_BITS_DEF = 24;
  localparam int COLOR_BITS     = 24;
  localparam int CH_BITS        = 8;
  localparam int RES_BITS       = 11;
  localparam int LANES          = 3;
  localparam int IDX_BITS       = 3;

  localparam logic [1:0] MODE_SPECTRUM = 2'd0;
  localparam logic [1:0] MODE_GRAY     = 2'd1;
  localparam logic [1:0] MODE_GRADIENT = 2'd2;

  localparam logic [IDX_BITS-1:0] REG_MODE        = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_RANGE_LOW   = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_RANGE_HIGH  = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_COLOR_START = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_COLOR_END   = 3'd4;

  localparam logic [RES_BITS-1:0] SPEC_TOP = 11'h5F9;
  localparam logic [RES_BITS-1:0] GRAY_TOP = 11'h0FF;

  localparam logic [RES_BITS-1:0] SEG_1 = 11'h0FF;
  localparam logic [RES_BITS-1:0] SEG_2 = 11'h1FE;
  localparam logic [RES_BITS-1:0] SEG_3 = 11'h2FD;
  localparam logic [RES_BITS-1:0] SEG_4 = 11'h3FC;
  localparam logic [RES_BITS-1:0] SEG_5 = 11'h4FB;

  localparam logic [COLOR_BITS-1:0] HUE_0 = 24'hFF00FE;
  localparam logic [COLOR_BITS-1:0] HUE_1 = 24'hFF0100;
  localparam logic [COLOR_BITS-1:0] HUE_2 = 24'hFEFF00;
  localparam logic [COLOR_BITS-1:0] HUE_3 = 24'h00FF01;
  localparam logic [COLOR_BITS-1:0] HUE_4 = 24'h00FEFF;
  localparam logic [COLOR_BITS-1:0] HUE_5 = 24'h0100FF;

  typedef struct packed {
    logic [RES_BITS-1:0] nlo;
    logic [RES_BITS-1:0] nhi;
    logic [RES_BITS-1:0] mag;
    logic                neg;
  } lane_t;

  typedef struct packed {
    logic oor;
    logic at_hi;
    logic at_lo;
  } tag_t;

  function automatic logic [COLOR_BITS-1:0] spectrum(input logic [RES_BITS-1:0] c);
    logic [COLOR_BITS-1:0] u;
    logic [COLOR_BITS-1:0] res;
    u = COLOR_BITS'(c);
    priority if (c < SEG_1) begin
      res = HUE_0 - u;
    end else if (c < SEG_2) begin
      res = HUE_1 + ((u - COLOR_BITS'(SEG_1)) << 8);
    end else if (c < SEG_3) begin
      res = HUE_2 - ((u - COLOR_BITS'(SEG_2)) << 16);
    end else if (c < SEG_4) begin
      res = HUE_3 + (u - COLOR_BITS'(SEG_3));
    end else if (c < SEG_5) begin
      res = HUE_4 - ((u - COLOR_BITS'(SEG_4)) << 8);
    end else begin
      res = HUE_5 + ((u - COLOR_BITS'(SEG_5)) << 16);
    end
    return res;
  endfunction

endpackage

// ----- sv/vcm_value_if.sv -----
interface vcm_value_if #(
  parameter int VALUE_BITS = vcm_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source(output valid, value, input ready);
  modport sink(input valid, value, output ready);
endinterface

// ----- sv/vcm_color_if.sv -----
interface vcm_color_if;
  logic                                 valid;
  logic                                 ready;
  logic [vcm_pkg::COLOR_BITS-1:0]       rgb;
  logic                                 out_of_range;

  modport source(output valid, rgb, out_of_range, input ready);
  modport sink(input valid, rgb, out_of_range, output ready);
endinterface

// ----- sv/vcm_cfg_if.sv -----
interface vcm_cfg_if #(
  parameter int DATA_BITS = vcm_pkg::COLOR_BITS
);
  logic                           valid;
  logic                           ready;
  logic [vcm_pkg::IDX_BITS-1:0]   index;
  logic [DATA_BITS-1:0]           data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/vcm_cfg.sv -----
module vcm_cfg #(
  parameter int VALUE_BITS = vcm_pkg::VALUE_BITS_DEF,
  parameter int DATA_BITS  = vcm_pkg::COLOR_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst,
  vcm_cfg_if.sink                                     cfg,
  output logic [1:0]                                  mode,
  output logic signed [VALUE_BITS-1:0]                lo,
  output logic signed [VALUE_BITS-1:0]                hi,
  output logic signed [VALUE_BITS-1:0]                bot,
  output logic signed [VALUE_BITS-1:0]                top,
  output logic [VALUE_BITS-1:0]                       span,
  output vcm_pkg::lane_t [vcm_pkg::LANES-1:0]         lane
);

  localparam int CH  = vcm_pkg::CH_BITS;
  localparam int NL  = vcm_pkg::LANES;
  localparam int RB  = vcm_pkg::RES_BITS;

  logic signed [VALUE_BITS-1:0]     range_low;
  logic signed [VALUE_BITS-1:0]     range_high;
  logic [vcm_pkg::COLOR_BITS-1:0]   start_rgb;
  logic [vcm_pkg::COLOR_BITS-1:0]   end_rgb;
  logic signed [VALUE_BITS:0]       diff;
  logic [VALUE_BITS:0]              diff_abs;
  vcm_pkg::lane_t [NL-1:0]          lane_next;

  assign cfg.ready = 1'b1;
  assign lo = range_low;
  assign hi = range_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= vcm_pkg::MODE_SPECTRUM;
      range_low   <= '0;
      range_high  <= VALUE_BITS'(100);
      start_rgb   <= '0;
      end_rgb     <= '1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        vcm_pkg::REG_MODE:        mode        <= cfg.data[1:0];
        vcm_pkg::REG_RANGE_LOW:   range_low   <= cfg.data[VALUE_BITS-1:0];
        vcm_pkg::REG_RANGE_HIGH:  range_high  <= cfg.data[VALUE_BITS-1:0];
        vcm_pkg::REG_COLOR_START: start_rgb   <= cfg.data[vcm_pkg::COLOR_BITS-1:0];
        vcm_pkg::REG_COLOR_END:   end_rgb     <= cfg.data[vcm_pkg::COLOR_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign diff     = {range_high[VALUE_BITS-1], range_high} - {range_low[VALUE_BITS-1], range_low};
  assign diff_abs = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      lane_next[l].nlo = '0;
      lane_next[l].nhi = vcm_pkg::SPEC_TOP;
      unique case (mode)
        vcm_pkg::MODE_GRAY: begin
          lane_next[l].nhi = vcm_pkg::GRAY_TOP;
        end
        vcm_pkg::MODE_GRADIENT: begin
          lane_next[l].nlo = RB'(start_rgb[CH*(NL-1-l) +: CH]);
          lane_next[l].nhi = RB'(end_rgb[CH*(NL-1-l) +: CH]);
        end
        default: ;
      endcase
      lane_next[l].neg = lane_next[l].nhi < lane_next[l].nlo;
      lane_next[l].mag = lane_next[l].neg ? (lane_next[l].nlo - lane_next[l].nhi)
                                          : (lane_next[l].nhi - lane_next[l].nlo);
    end
  end

  always_ff @(posedge clk) begin
    bot  <= (range_low < range_high) ? range_low : range_high;
    top  <= (range_low < range_high) ? range_high : range_low;
    span <= diff_abs[VALUE_BITS-1:0];
    lane <= lane_next;
  end

endmodule

// ----- sv/vcm_front.sv -----
module vcm_front #(
  parameter int VALUE_BITS = vcm_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         adv,
  input  logic                         in_valid,
  input  logic signed [VALUE_BITS-1:0] value,
  input  logic signed [VALUE_BITS-1:0] lo,
  input  logic signed [VALUE_BITS-1:0] hi,
  input  logic signed [VALUE_BITS-1:0] bot,
  input  logic signed [VALUE_BITS-1:0] top,
  output logic                         out_valid,
  output logic [VALUE_BITS-1:0]        offset,
  output vcm_pkg::tag_t                tag
);

  logic                         val0;
  logic                         val1;
  logic signed [VALUE_BITS-1:0] v0;
  logic signed [VALUE_BITS-1:0] vc;
  logic                         oor1;
  logic signed [VALUE_BITS:0]   diff;
  logic [VALUE_BITS:0]          diff_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      val0      <= 1'b0;
      val1      <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      val0      <= in_valid;
      val1      <= val0;
      out_valid <= val1;
    end
  end

  assign diff     = {vc[VALUE_BITS-1], vc} - {lo[VALUE_BITS-1], lo};
  assign diff_abs = diff[VALUE_BITS] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    if (adv) begin
      v0 <= value;
      priority if (v0 < bot) begin
        vc   <= bot;
        oor1 <= 1'b1;
      end else if (v0 > top) begin
        vc   <= top;
        oor1 <= 1'b1;
      end else begin
        vc   <= v0;
        oor1 <= 1'b0;
      end
      offset    <= diff_abs[VALUE_BITS-1:0];
      tag.oor   <= oor1;
      tag.at_hi <= vc == hi;
      tag.at_lo <= vc == lo;
    end
  end

endmodule

// ----- sv/vcm_divider.sv -----
module vcm_divider #(
  parameter int VALUE_BITS = vcm_pkg::VALUE_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            adv,
  input  logic                                            in_valid,
  input  logic [VALUE_BITS-1:0]                           offset,
  input  vcm_pkg::tag_t                                   in_tag,
  input  logic [VALUE_BITS-1:0]                           span,
  input  vcm_pkg::lane_t [vcm_pkg::LANES-1:0]             lane,
  output logic                                            out_valid,
  output vcm_pkg::tag_t                                   out_tag,
  output logic [vcm_pkg::LANES-1:0][vcm_pkg::RES_BITS-1:0] quo
);

  localparam int QB = vcm_pkg::RES_BITS;
  localparam int NL = vcm_pkg::LANES;
  localparam int PW = VALUE_BITS + QB;

  logic [QB:0]                         vld;
  vcm_pkg::tag_t [QB:0]                tg;
  logic [NL-1:0][QB:0][VALUE_BITS-1:0] rem;
  logic [NL-1:0][QB:0][QB-1:0]         low;
  logic [NL-1:0][QB:0][QB-1:0]         qs;
  logic [NL-1:0][PW-1:0]               prod;
  logic [NL-1:0][QB-1:0][VALUE_BITS:0] trial;
  logic [NL-1:0][QB-1:0][VALUE_BITS:0] sub;
  logic [NL-1:0][QB-1:0]               ge;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      prod[l] = PW'(offset) * PW'(lane[l].mag);
      for (int k = 0; k < QB; k++) begin
        trial[l][k] = {rem[l][k], low[l][k][QB-1-k]};
        ge[l][k]    = trial[l][k] >= {1'b0, span};
        sub[l][k]   = trial[l][k] - {1'b0, span};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[QB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tg <= {tg[QB-1:0], in_tag};
      for (int l = 0; l < NL; l++) begin
        rem[l][0] <= prod[l][PW-1:QB];
        low[l][0] <= prod[l][QB-1:0];
        qs[l][0]  <= '0;
        for (int k = 0; k < QB; k++) begin
          rem[l][k+1] <= ge[l][k] ? sub[l][k][VALUE_BITS-1:0] : trial[l][k][VALUE_BITS-1:0];
          low[l][k+1] <= low[l][k];
          qs[l][k+1]  <= {qs[l][k][QB-2:0], ge[l][k]};
        end
      end
    end
  end

  assign out_valid = vld[QB];
  assign out_tag   = tg[QB];

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      quo[l] = qs[l][QB];
    end
  end

`ifndef SYNTHESIS
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (vld[QB] && !tg[QB].at_hi && !tg[QB].at_lo) |-> (qs[0][QB] <= lane[0].mag))
    else $error("quotient exceeds channel span");
`endif

endmodule

// ----- sv/vcm_back.sv -----
module vcm_back (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              adv,
  input  logic                                              in_valid,
  input  vcm_pkg::tag_t                                     in_tag,
  input  logic [vcm_pkg::LANES-1:0][vcm_pkg::RES_BITS-1:0]  quo,
  input  logic [1:0]                                        mode,
  input  vcm_pkg::lane_t [vcm_pkg::LANES-1:0]               lane,
  output logic                                              out_valid,
  output logic [vcm_pkg::COLOR_BITS-1:0]                    rgb,
  output logic                                              oor
);

  localparam int NL = vcm_pkg::LANES;
  localparam int RB = vcm_pkg::RES_BITS;
  localparam int CH = vcm_pkg::CH_BITS;

  logic                  res_valid;
  logic                  res_oor;
  logic [NL-1:0][RB-1:0] res;
  logic [NL-1:0][RB-1:0] res_next;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      priority if (in_tag.at_hi) begin
        res_next[l] = lane[l].nhi;
      end else if (in_tag.at_lo) begin
        res_next[l] = lane[l].nlo;
      end else if (lane[l].neg) begin
        res_next[l] = lane[l].nlo - quo[l];
      end else begin
        res_next[l] = lane[l].nlo + quo[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= in_valid;
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res     <= res_next;
      res_oor <= in_tag.oor;
      oor     <= res_oor;
      unique case (mode)
        vcm_pkg::MODE_SPECTRUM: rgb <= vcm_pkg::spectrum(res[0]);
        vcm_pkg::MODE_GRAY:     rgb <= {res[0][CH-1:0], res[0][CH-1:0], res[0][CH-1:0]};
        vcm_pkg::MODE_GRADIENT: rgb <= {res[0][CH-1:0], res[1][CH-1:0], res[2][CH-1:0]};
        default:                rgb <= '0;
      endcase
    end
  end

endmodule

// ----- sv/value_to_color_map.sv -----
// Value to color map: turns one signed sample into a 24-bit 0xRRGGBB color.
// Channels: sample (valid/ready, field value) in, color (valid/ready, fields
// rgb and out_of_range) out, cfg (valid/ready, index and data) for the five
// registers mode, range_low, range_high, start_rgb, end_rgb.
// Modes: rainbow spectrum, grayscale, or a two-color gradient over the range.
// Samples outside the range are clamped and flagged with out_of_range.
// Throughput: one item per cycle while the receiver does not stall. Stages
// are the input register, the clamp and offset stages, one multiply stage,
// an 11-stage restoring divider (one quotient bit per stage, three lanes in
// parallel for the gradient channels), a rescale stage and the output
// register.
// Reset clears all valid bits and loads mode 0, range 0..100, start color
// black and end color white. cfg is always ready; write it only while no
// item is in flight.
// A stalled receiver freezes the whole pipeline: sample.ready follows
// !color.valid || color.ready, so nothing is dropped or repeated.
module value_to_color_map #(
  parameter int VALUE_BITS = vcm_pkg::VALUE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  vcm_value_if.sink      sample,
  vcm_color_if.source    color,
  vcm_cfg_if.sink        cfg
);

  localparam int CfgBits = (VALUE_BITS > vcm_pkg::COLOR_BITS) ? VALUE_BITS
                                                              : vcm_pkg::COLOR_BITS;

  logic                                             adv;
  logic [1:0]                                       mode;
  logic signed [VALUE_BITS-1:0]                     lo;
  logic signed [VALUE_BITS-1:0]                     hi;
  logic signed [VALUE_BITS-1:0]                     bot;
  logic signed [VALUE_BITS-1:0]                     top;
  logic [VALUE_BITS-1:0]                            span;
  vcm_pkg::lane_t [vcm_pkg::LANES-1:0]              lane;
  logic                                             front_valid;
  logic [VALUE_BITS-1:0]                            offset;
  vcm_pkg::tag_t                                    front_tag;
  logic                                             div_valid;
  vcm_pkg::tag_t                                    div_tag;
  logic [vcm_pkg::LANES-1:0][vcm_pkg::RES_BITS-1:0] quo;

  assign adv          = !color.valid || color.ready;
  assign sample.ready = adv;

  vcm_cfg #(
    .VALUE_BITS (VALUE_BITS),
    .DATA_BITS  (CfgBits)
  ) u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .mode (mode),
    .lo   (lo),
    .hi   (hi),
    .bot  (bot),
    .top  (top),
    .span (span),
    .lane (lane)
  );

  vcm_front #(
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (sample.valid),
    .value     (sample.value),
    .lo        (lo),
    .hi        (hi),
    .bot       (bot),
    .top       (top),
    .out_valid (front_valid),
    .offset    (offset),
    .tag       (front_tag)
  );

  vcm_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (front_valid),
    .offset    (offset),
    .in_tag    (front_tag),
    .span      (span),
    .lane      (lane),
    .out_valid (div_valid),
    .out_tag   (div_tag),
    .quo       (quo)
  );

  vcm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (div_valid),
    .in_tag    (div_tag),
    .quo       (quo),
    .mode      (mode),
    .lane      (lane),
    .out_valid (color.valid),
    .rgb       (color.rgb),
    .oor       (color.out_of_range)
  );

`ifndef SYNTHESIS
  a_unused_mode_black: assert property (@(posedge clk) disable iff (rst)
    (color.valid && mode != vcm_pkg::MODE_SPECTRUM && mode != vcm_pkg::MODE_GRAY &&
     mode != vcm_pkg::MODE_GRADIENT) |-> (color.rgb == '0))
    else $error("unused mode gave a nonzero color");

  a_gray_channels: assert property (@(posedge clk) disable iff (rst)
    (color.valid && mode == vcm_pkg::MODE_GRAY) |->
    (color.rgb[23:16] == color.rgb[15:8] && color.rgb[15:8] == color.rgb[7:0]))
    else $error("gray color with unequal channels");

  a_spectrum_full: assert property (@(posedge clk) disable iff (rst)
    (color.valid && mode == vcm_pkg::MODE_SPECTRUM) |->
    (color.rgb[23:16] == 8'hFF || color.rgb[15:8] == 8'hFF || color.rgb[7:0] == 8'hFF))
    else $error("spectrum color without a saturated channel");
`endif

endmodule
